// ----- hdl/mbf_pkg.sv -----
// Shared constants, types and channel arithmetic for the mipmap box filter chain.
package mbf_pkg;

  // Default sizing
  localparam int MaxSizeLog2Def = 11;
  localparam int MaxLevelsDef   = 11;

  // Fixed field widths
  localparam int CNT_W  = 11;  // position counters wrap at 2^11
  localparam int LVL_W  = 4;   // level field
  localparam int POS_W  = 10;  // pos_x / pos_y fields
  localparam int CH_W   = 8;   // one color channel
  localparam int PSUM_W = 10;  // one channel of a horizontal pair sum
  localparam int TEX_W  = 4 * CH_W;
  localparam int LINE_W = 4 * PSUM_W;

  // Configuration register indexes
  localparam logic [1:0] CFG_WIDTH_LOG2  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT_LOG2 = 2'd1;
  localparam logic [1:0] CFG_HAS_ALPHA   = 2'd2;
  localparam logic [1:0] CFG_LEVEL_COUNT = 2'd3;

  // Counter bank control: clear all positions or advance one level's position
  typedef struct packed {
    logic       clear;
    logic       adv;
    logic [3:0] lvl;
  } cnt_ctl_t;

  // Per-channel sum of two texels
  function automatic logic [LINE_W-1:0] pair_sum(input logic [TEX_W-1:0] a,
                                                 input logic [TEX_W-1:0] b);
    logic [LINE_W-1:0] r;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      r[i*PSUM_W +: PSUM_W] = PSUM_W'(a[i*CH_W +: CH_W]) + PSUM_W'(b[i*CH_W +: CH_W]);
    end
    return r;
  endfunction

  // (sum of four + 2) >> 2 per channel from two pair sums
  function automatic logic [TEX_W-1:0] avg4(input logic [LINE_W-1:0] a,
                                            input logic [LINE_W-1:0] b);
    logic [TEX_W-1:0] r;
    logic [PSUM_W+1:0] s;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      s = (PSUM_W+2)'(a[i*PSUM_W +: PSUM_W]) + (PSUM_W+2)'(b[i*PSUM_W +: PSUM_W]) +
          (PSUM_W+2)'(2);
      r[i*CH_W +: CH_W] = s[CH_W+1:2];
    end
    return r;
  endfunction

  // Two texels each counted twice: (a + b + 1) >> 1 per channel
  function automatic logic [TEX_W-1:0] avg2(input logic [TEX_W-1:0] a,
                                            input logic [TEX_W-1:0] b);
    logic [TEX_W-1:0] r;
    logic [CH_W:0] s;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      s = (CH_W+1)'(a[i*CH_W +: CH_W]) + (CH_W+1)'(b[i*CH_W +: CH_W]) + (CH_W+1)'(1);
      r[i*CH_W +: CH_W] = s[CH_W:1];
    end
    return r;
  endfunction

endpackage

// ----- hdl/mbf_ram.sv -----
// Generic single-port synchronous RAM with registered read and read enable.
module mbf_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and held read register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- hdl/mbf_pos_cnt.sv -----
// Per-level column and row counters of the mipmap chain.
module mbf_pos_cnt
  import mbf_pkg::*;
#(
  parameter int MAX_SIZE_LOG2 = MaxSizeLog2Def,
  parameter int MAX_LEVELS    = MaxLevelsDef
) (
  input  logic             clk,
  input  logic             rst,
  input  cnt_ctl_t         ctl,
  input  logic [3:0]       wl,
  input  logic [3:0]       hl,
  output logic [CNT_W-1:0] x,
  output logic [CNT_W-1:0] y
);

  localparam int DEPTH = MAX_LEVELS + 1;
  localparam int KW    = $clog2(DEPTH);
  localparam int SW    = (MAX_SIZE_LOG2 + 1 > CNT_W + 1) ? MAX_SIZE_LOG2 + 1 : CNT_W + 1;

  logic [CNT_W-1:0] col [DEPTH];
  logic [CNT_W-1:0] row [DEPTH];
  logic [KW-1:0]    k;
  logic [3:0]       wk, hk;
  logic [SW-1:0]    w, h;
  logic [CNT_W-1:0] col_next, row_next, col_inc, row_inc;

  assign k = ctl.lvl[KW-1:0];
  assign x = col[k];
  assign y = row[k];

  // Next position of the selected level
  always_comb begin
    wk = (wl > ctl.lvl) ? wl - ctl.lvl : 4'd0;
    hk = (hl > ctl.lvl) ? hl - ctl.lvl : 4'd0;
    w  = SW'(1) << wk;
    h  = SW'(1) << hk;
    col_inc  = col[k] + CNT_W'(1);
    row_inc  = row[k] + CNT_W'(1);
    col_next = col_inc;
    row_next = row[k];
    if (SW'(col_inc) >= w) begin
      col_next = '0;
      row_next = (SW'(row_inc) >= h) ? '0 : row_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int i = 0; i < DEPTH; i++) begin
        col[i] <= '0;
        row[i] <= '0;
      end
    end else if (ctl.adv) begin
      col[k] <= col_next;
      row[k] <= row_next;
    end
  end

endmodule

// ----- hdl/mipmap_box_filter_chain_unit.sv -----
// Top level: streaming 2x2 box-filter mipmap chain generator.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------
//  in      | input     | in_valid/in_stall  | red green blue alpha
//  out     | output    | out_valid/out_stall| level pos_x pos_y out_* last
//  cfg     | input     | cfg_we             | cfg_index cfg_data
//
// The level sequencer walks one level per cycle while the output is not stalled: a base
// texel that yields no smaller texel needs only its level 0 step, one that yields n
// texels n more steps, the pair line memory read feeding the next level's step.
// Input is stalled only while the sequencer walks the lower levels of an earlier texel.
// A stalled output freezes the sequencer; the output register frees the input side.
// Reset is synchronous; position counters clear on reset and on any config write.
module mipmap_box_filter_chain_unit
  import mbf_pkg::*;
#(
  parameter int MAX_SIZE_LOG2 = MaxSizeLog2Def,
  parameter int MAX_LEVELS    = MaxLevelsDef
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [3:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CH_W-1:0]   red,
  input  logic [CH_W-1:0]   green,
  input  logic [CH_W-1:0]   blue,
  input  logic [CH_W-1:0]   alpha,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [LVL_W-1:0]  level,
  output logic [POS_W-1:0]  pos_x,
  output logic [POS_W-1:0]  pos_y,
  output logic [CH_W-1:0]   out_red,
  output logic [CH_W-1:0]   out_green,
  output logic [CH_W-1:0]   out_blue,
  output logic [CH_W-1:0]   out_alpha,
  output logic              last
);

  localparam int AW = MAX_SIZE_LOG2;
  localparam int HW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int SW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
  localparam logic [3:0] MaxSize = 4'(MAX_SIZE_LOG2);
  localparam logic [3:0] MaxLev  = 4'(MAX_LEVELS);

  // Configuration registers
  logic [3:0] width_log2, height_log2, level_count;
  logic       has_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_log2  <= 4'd8;
      height_log2 <= 4'd8;
      has_alpha   <= 1'b1;
      level_count <= 4'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH_LOG2:  width_log2  <= cfg_data;
        CFG_HEIGHT_LOG2: height_log2 <= cfg_data;
        CFG_HAS_ALPHA:   has_alpha   <= cfg_data[0];
        CFG_LEVEL_COUNT: level_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective sizes and level count
  logic [3:0] wl, hl, top, nlev;
  always_comb begin
    wl   = (width_log2 > MaxSize) ? MaxSize : width_log2;
    hl   = (height_log2 > MaxSize) ? MaxSize : height_log2;
    top  = (wl > hl) ? wl : hl;
    nlev = (level_count > MaxLev) ? MaxLev : level_count;
    if (nlev > top) nlev = top;
  end

  // Sequencer state
  logic              pend;
  logic [3:0]        kq;
  logic              pend2d;
  logic [LINE_W-1:0] p_prev;
  logic [TEX_W-1:0]  cur_c;
  logic [TEX_W-1:0]  held [MAX_LEVELS];
  logic [LINE_W-1:0] line_rdata;

  logic              out_free, step, emit;
  logic [3:0]        k_cur;
  logic [TEX_W-1:0]  c, held_k, res1d;
  logic [LINE_W-1:0] p_cur;
  logic [CNT_W-1:0]  x, y;
  logic              twod, active, odd_pos, produce, prod2d;
  logic              line_we, line_re, held_we;
  logic [SW-1:0]     wfull, idx_sum;
  logic [AW-1:0]     idx;
  cnt_ctl_t          cnt_ctl;

  assign out_free = !out_valid || !out_stall;
  assign step     = pend ? out_free : in_valid;
  assign emit     = step && pend;
  assign k_cur    = pend ? kq : 4'd0;
  assign in_stall = pend;

  // Texel entering this level
  always_comb begin
    if (!pend) begin
      c = {(has_alpha ? alpha : 8'd0), blue, green, red};
    end else if (pend2d) begin
      c = avg4(p_prev, line_rdata);
    end else begin
      c = cur_c;
    end
  end

  assign held_k = held[k_cur[HW-1:0]];
  assign p_cur  = pair_sum(held_k, c);
  assign res1d  = avg2(held_k, c);

  // Level decision
  always_comb begin
    twod    = (wl > k_cur) && (hl > k_cur);
    active  = k_cur < nlev;
    odd_pos = twod ? x[0] : ((wl > k_cur) ? x[0] : y[0]);
    held_we = step && active && !odd_pos;
    line_we = step && active && twod && x[0] && !y[0];
    line_re = step && active && twod && x[0] && y[0];
    prod2d  = active && twod && x[0] && y[0];
    produce = active && odd_pos && (!twod || y[0]);
  end

  // Pair line address: levels packed one after another
  always_comb begin
    wfull   = SW'(1) << wl;
    idx_sum = wfull - (wfull >> k_cur) + SW'(x >> 1);
    idx     = idx_sum[AW-1:0];
  end

  assign cnt_ctl = '{clear: cfg_we, adv: step, lvl: k_cur};

  mbf_pos_cnt #(
    .MAX_SIZE_LOG2 (MAX_SIZE_LOG2),
    .MAX_LEVELS    (MAX_LEVELS)
  ) u_cnt (
    .clk (clk),
    .rst (rst),
    .ctl (cnt_ctl),
    .wl  (wl),
    .hl  (hl),
    .x   (x),
    .y   (y)
  );

  mbf_ram #(
    .WIDTH (LINE_W),
    .DEPTH (1 << AW)
  ) u_lines (
    .clk   (clk),
    .we    (line_we),
    .re    (line_re),
    .addr  (idx),
    .wdata (p_cur),
    .rdata (line_rdata)
  );

  // Held left texels
  always_ff @(posedge clk) begin
    if (held_we) begin
      held[k_cur[HW-1:0]] <= c;
    end
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      kq   <= 4'd0;
    end else if (step) begin
      pend <= produce;
      kq   <= k_cur + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pend2d <= prod2d;
      p_prev <= p_cur;
      cur_c  <= res1d;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      level     <= k_cur;
      pos_x     <= x[POS_W-1:0];
      pos_y     <= y[POS_W-1:0];
      out_red   <= c[0*CH_W +: CH_W];
      out_green <= c[1*CH_W +: CH_W];
      out_blue  <= c[2*CH_W +: CH_W];
      out_alpha <= c[3*CH_W +: CH_W];
      last      <= !produce;
    end
  end

endmodule
